[design/u16u8_pkg.sv]
// Package for the UTF-16 to UTF-8 encoder.
// Holds the queue entry and status types and the surrogate and code point constants.
// No dependencies.
`default_nettype none

package u16u8_pkg;

    localparam int CP_W = 21;                       // code point up to 0x10FFFF

    localparam logic [5:0]      HIGH_SURR_TAG = 6'b110110;   // 0xD800..0xDBFF
    localparam logic [5:0]      LOW_SURR_TAG  = 6'b110111;   // 0xDC00..0xDFFF
    localparam logic [CP_W-1:0] REPLACEMENT   = 21'h00FFFD;
    localparam logic [10:0]     PLANE_OFFSET  = 11'd64;      // 0x10000 >> 10

    // one decoded code point waiting to be serialized
    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            repl;
        logic            last;
    } t_entry;

    // queue status seen by both sides
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage

`default_nettype wire

[design/u16u8_front.sv]
// Front end: accepts code units, holds a pending surrogate, forms code points.
// Depends on u16u8_pkg.
`default_nettype none

module u16u8_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_accept,
    input  wire logic [15:0]          i_code_unit,
    input  wire logic                 i_string_end,
    output logic                      o_wr,
    output u16u8_pkg::t_entry         o_entry
);

    logic        r_pend_valid;
    logic [15:0] r_pend_unit;
    logic        n_pend_valid;
    logic [15:0] n_pend_unit;

    logic u_high, u_low, u_surr, p_high, p_low;

    assign u_high = (i_code_unit[15:10] == u16u8_pkg::HIGH_SURR_TAG);
    assign u_low  = (i_code_unit[15:10] == u16u8_pkg::LOW_SURR_TAG);
    assign u_surr = u_high || u_low;
    assign p_high = (r_pend_unit[15:10] == u16u8_pkg::HIGH_SURR_TAG);
    assign p_low  = (r_pend_unit[15:10] == u16u8_pkg::LOW_SURR_TAG);

    always_comb begin
        n_pend_valid  = r_pend_valid;
        n_pend_unit   = r_pend_unit;
        o_wr          = 1'b0;
        o_entry.cp    = {5'd0, i_code_unit};
        o_entry.repl  = 1'b0;
        o_entry.last  = i_string_end;
        if (i_accept) begin
            priority if (r_pend_valid) begin
                n_pend_valid = 1'b0;
                n_pend_unit  = '0;
                o_wr         = 1'b1;
                if (p_high && u_low) begin
                    o_entry.cp = {{1'b0, r_pend_unit[9:0]} + u16u8_pkg::PLANE_OFFSET,
                                  i_code_unit[9:0]};
                end else if (p_low && u_high) begin
                    o_entry.cp = {{1'b0, i_code_unit[9:0]} + u16u8_pkg::PLANE_OFFSET,
                                  r_pend_unit[9:0]};
                end else begin
                    o_entry.cp   = u16u8_pkg::REPLACEMENT;
                    o_entry.repl = 1'b1;
                end
            end else if (u_surr && !i_string_end) begin
                n_pend_valid = 1'b1;
                n_pend_unit  = i_code_unit;
            end else if (u_surr) begin
                // lone surrogate closing the string
                o_wr         = 1'b1;
                o_entry.cp   = u16u8_pkg::REPLACEMENT;
                o_entry.repl = 1'b1;
            end else begin
                o_wr = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_pend_unit  <= '0;
        end else begin
            r_pend_valid <= n_pend_valid;
            r_pend_unit  <= n_pend_unit;
        end
    end

endmodule

`default_nettype wire

[design/u16u8_queue.sv]
// Small FIFO of decoded code points between the front and back ends.
// Depends on u16u8_pkg.
`default_nettype none

module u16u8_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_wr,
    input  wire u16u8_pkg::t_entry    i_entry,
    input  wire logic                 i_rd,
    output u16u8_pkg::t_entry         o_head,
    output u16u8_pkg::t_q_status      o_status
);

    localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    u16u8_pkg::t_entry r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr, n_wr_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              do_wr, do_rd;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign do_wr = i_wr && !o_status.full;
    assign do_rd = i_rd && !o_status.empty;
    assign o_head = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        unique case ({do_wr, do_rd})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

[design/u16u8_back.sv]
// Back end: serializes queued code points into UTF-8 bytes for a registered
// output stage, one per cycle when it is free or popped. Depends on u16u8_pkg.
`default_nettype none

module u16u8_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire u16u8_pkg::t_entry    i_head,
    input  wire u16u8_pkg::t_q_status i_q_status,
    output logic                      o_q_rd,
    input  wire logic                 i_pop,
    output logic                      o_empty,
    output logic [7:0]                o_out_byte,
    output logic                      o_run_last,
    output logic                      o_string_done,
    output logic                      o_replaced
);

    logic       r_valid, n_valid;
    logic [1:0] r_idx, n_idx;
    logic [7:0] r_byte;
    logic       r_run_last, r_done, r_repl;

    logic [1:0] len_m1;     // byte count minus one
    logic [1:0] rem;        // bytes still to follow the current one
    logic [7:0] cur_byte;
    logic       cur_last;
    logic       load;

    logic [u16u8_pkg::CP_W-1:0] cp;
    assign cp = i_head.cp;

    always_comb begin
        priority if (cp[20:16] != '0) len_m1 = 2'd3;
        else if (cp[15:11] != '0)     len_m1 = 2'd2;
        else if (cp[10:7] != '0)      len_m1 = 2'd1;
        else                          len_m1 = 2'd0;
    end

    assign rem      = len_m1 - r_idx;
    assign cur_last = (r_idx == len_m1);

    always_comb begin
        if (r_idx == 2'd0) begin
            unique case (len_m1)
                2'd3:    cur_byte = {5'b11110, cp[20:18]};
                2'd2:    cur_byte = {4'b1110, cp[15:12]};
                2'd1:    cur_byte = {3'b110, cp[10:6]};
                default: cur_byte = {1'b0, cp[6:0]};
            endcase
        end else begin
            unique case (rem)
                2'd2:    cur_byte = {2'b10, cp[17:12]};
                2'd1:    cur_byte = {2'b10, cp[11:6]};
                default: cur_byte = {2'b10, cp[5:0]};
            endcase
        end
    end

    // output stage takes a new byte when it is free or being drained
    assign load   = !i_q_status.empty && (!r_valid || i_pop);
    assign o_q_rd = load && cur_last;

    always_comb begin
        n_valid = r_valid;
        n_idx   = r_idx;
        if (load) begin
            n_valid = 1'b1;
            n_idx   = cur_last ? 2'd0 : r_idx + 2'd1;
        end else if (i_pop) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte     <= cur_byte;
            r_run_last <= cur_last;
            r_done     <= cur_last && i_head.last;
            r_repl     <= i_head.repl;
        end
    end

    assign o_empty       = !r_valid;
    assign o_out_byte    = r_byte;
    assign o_run_last    = r_run_last;
    assign o_string_done = r_done;
    assign o_replaced    = r_repl;

endmodule

`default_nettype wire

[design/utf16_to_utf8_encoder_top.sv]
// UTF-16 to UTF-8 encoder, top level.
// Depends on u16u8_pkg, u16u8_front, u16u8_queue, u16u8_back.
// Usage:
//   Input channel is a queue write port: drive i_code_unit / i_string_end and
//   raise push; the unit is taken on a clock edge where push=1 and full=0.
//   Output channel is a queue read port: while empty=0 the oldest UTF-8 byte
//   sits on o_out_byte with its flags; pop=1 on an edge consumes it.
//   Each unit yields 0 (held surrogate), 1, 2, 3 or 4 bytes. o_run_last marks
//   the last byte of a unit, o_string_done the last byte of the string, and
//   o_replaced every byte of an EF BF BD replacement.
// Path: each code point is queued, then serialized into the output register.
// Throughput: output is one byte per cycle while the receiver pops; a unit
//   produces 1..3 bytes for BMP characters, 4 for a surrogate pair (spread
//   over two units). The byte serializer in the back end sets this rate.
// The front end takes one unit per cycle while full is low into a
//   QUEUE_DEPTH-entry queue, so input keeps flowing as longer characters drain.
// Reset (synchronous, active low) empties the queue and output stage and
//   drops any held surrogate.
// If the receiver stalls, the output byte holds and full rises once QUEUE_DEPTH
//   code points wait, the one being serialized counting until its last byte.
`default_nettype none

module utf16_to_utf8_encoder_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [15:0] i_code_unit,
    input  wire logic        i_string_end,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       o_out_byte,
    output logic             o_run_last,
    output logic             o_string_done,
    output logic             o_replaced
);

    u16u8_pkg::t_entry    fe_entry;
    u16u8_pkg::t_entry    q_head;
    u16u8_pkg::t_q_status q_status;
    logic                 fe_wr;
    logic                 q_rd;

    // a unit is taken whenever the queue has room, even if it only gets held
    assign full = q_status.full;

    u16u8_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (push && !q_status.full),
        .i_code_unit  (i_code_unit),
        .i_string_end (i_string_end),
        .o_wr         (fe_wr),
        .o_entry      (fe_entry)
    );

    u16u8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (fe_wr),
        .i_entry  (fe_entry),
        .i_rd     (q_rd),
        .o_head   (q_head),
        .o_status (q_status)
    );

    u16u8_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (q_head),
        .i_q_status    (q_status),
        .o_q_rd        (q_rd),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_out_byte    (o_out_byte),
        .o_run_last    (o_run_last),
        .o_string_done (o_string_done),
        .o_replaced    (o_replaced)
    );

endmodule

`default_nettype wire

[design/u16u8_checker.sv]
// Port-level checker for the UTF-16 to UTF-8 encoder, plus its bind.
// Depends only on the top level's ports.
`default_nettype none

module u16u8_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic [7:0] o_out_byte,
    input wire logic       o_run_last,
    input wire logic       o_string_done,
    input wire logic       o_replaced
);

    // stalled byte holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_out_byte) && $stable(o_run_last))
        else $error("output byte changed while stalled");

    // end of string only on the last byte of a unit
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_string_done |-> o_run_last)
        else $error("string_done without run_last");

    // replacement bytes are EF BF BD
    a_repl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_replaced |->
            (o_out_byte == 8'hEF || o_out_byte == 8'hBF || o_out_byte == 8'hBD))
        else $error("bad replacement byte");

    // a multi-byte run continues at once with a continuation byte
    a_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && pop && !o_run_last |=> !empty && o_out_byte[7:6] == 2'b10)
        else $error("broken multi-byte sequence");

endmodule

bind utf16_to_utf8_encoder_top u16u8_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .empty         (empty),
    .pop           (pop),
    .o_out_byte    (o_out_byte),
    .o_run_last    (o_run_last),
    .o_string_done (o_string_done),
    .o_replaced    (o_replaced)
);

`default_nettype wire

[bench/tb_utf16_to_utf8_encoder_top.sv]
// Self-checking bench for utf16_to_utf8_encoder_top: streams UTF-16 words in, predicts
// the UTF-8 bytes with their flags and checks every popped byte in order.
// Depends on design/u16u8_pkg.sv and the encoder RTL.
module tb_utf16_to_utf8_encoder_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD  = 6;     // 12 ns clock
    localparam int STALL_LIMIT  = 4000;  // cycles with no word moving on either side
    localparam int DRAIN_CYCLES = 8;     // settle time after the last expected byte
    localparam int HOLD_CYCLES  = 80;    // long receiver hold-off
    localparam int MAX_PRINTS   = 40;    // mismatch lines printed before going quiet

    // one expected UTF-8 byte with its flags
    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       string_done;
        logic       replaced;
    } t_utf8_word;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        push         = 1'b0;
    logic        full;
    logic [15:0] i_code_unit  = '0;
    logic        i_string_end = 1'b0;
    logic        empty;
    logic        pop          = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_run_last;
    logic        o_string_done;
    logic        o_replaced;

    // predictor state: the surrogate waiting for its partner
    logic        held_valid = 1'b0;
    logic [15:0] held_unit  = '0;

    t_utf8_word  expected_utf8[$];   // bytes predicted but not yet popped
    int          errors       = 0;
    int          quiet_cycles = 0;
    int          tx_idle_pct  = 0;   // chance per cycle that the sender holds push low
    int          rx_idle_pct  = 0;   // chance per cycle that the receiver holds pop low
    int          hold_req     = 0;   // hold-off length handed to the receiver process

    utf16_to_utf8_encoder_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_code_unit  (i_code_unit),
        .i_string_end (i_string_end),
        .empty        (empty),
        .pop          (pop),
        .o_out_byte   (o_out_byte),
        .o_run_last   (o_run_last),
        .o_string_done(o_string_done),
        .o_replaced   (o_replaced)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic is_high_surr(input logic [15:0] u);
        return u[15:10] == u16u8_pkg::HIGH_SURR_TAG;
    endfunction

    function automatic logic is_low_surr(input logic [15:0] u);
        return u[15:10] == u16u8_pkg::LOW_SURR_TAG;
    endfunction

    // Takes one accepted UTF-16 word, updates the held surrogate and queues
    // the UTF-8 bytes it completes (none while a surrogate is only held).
    function automatic void predict_utf8(input logic [15:0] unit, input logic is_last);
        logic [u16u8_pkg::CP_W-1:0] cp;
        logic                       repl;
        logic [7:0]                 b [4];
        int                         n;
        t_utf8_word                 w;

        repl = 1'b0;
        if (held_valid) begin
            // partner of a held surrogate: pair in either order, else U+FFFD
            held_valid = 1'b0;
            if (is_high_surr(held_unit) && is_low_surr(unit)) begin
                cp = {u16u8_pkg::PLANE_OFFSET, 10'd0}
                     + {1'b0, held_unit[9:0], unit[9:0]};
            end else if (is_low_surr(held_unit) && is_high_surr(unit)) begin
                cp = {u16u8_pkg::PLANE_OFFSET, 10'd0}
                     + {1'b0, unit[9:0], held_unit[9:0]};
            end else begin
                cp   = u16u8_pkg::REPLACEMENT;
                repl = 1'b1;
            end
            held_unit = '0;
        end else if (is_high_surr(unit) || is_low_surr(unit)) begin
            if (!is_last) begin
                held_valid = 1'b1;
                held_unit  = unit;
                return;
            end
            // lone surrogate closing the string
            cp   = u16u8_pkg::REPLACEMENT;
            repl = 1'b1;
        end else begin
            cp = {5'd0, unit};
        end

        if (cp > 21'h00FFFF) begin
            n    = 4;
            b[0] = {5'b11110, cp[20:18]};
            b[1] = {2'b10, cp[17:12]};
            b[2] = {2'b10, cp[11:6]};
            b[3] = {2'b10, cp[5:0]};
        end else if (cp > 21'h0007FF) begin
            n    = 3;
            b[0] = {4'b1110, cp[15:12]};
            b[1] = {2'b10, cp[11:6]};
            b[2] = {2'b10, cp[5:0]};
        end else if (cp > 21'h00007F) begin
            n    = 2;
            b[0] = {3'b110, cp[10:6]};
            b[1] = {2'b10, cp[5:0]};
        end else begin
            n    = 1;
            b[0] = {1'b0, cp[6:0]};
        end

        for (int k = 0; k < n; k++) begin
            w.data        = b[k];
            w.run_last    = (k == n - 1);
            w.string_done = (k == n - 1) && is_last;
            w.replaced    = repl;
            expected_utf8 = {expected_utf8, w};
        end
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("MISMATCH at %0t ns: %s got %02h want %02h", $time, what, got, want);
    endtask

    // pop && !empty sampled at the edge: values read here are the pre-edge ones
    always @(posedge i_clk) begin : byte_check
        t_utf8_word want;
        if (i_rst_n && pop && !empty) begin
            if (expected_utf8.size() == 0) begin
                report_mismatch("byte with nothing expected", o_out_byte, 8'h00);
            end else begin
                want = expected_utf8.pop_front();
                if (o_out_byte !== want.data)
                    report_mismatch("out_byte", o_out_byte, want.data);
                if (o_run_last !== want.run_last)
                    report_mismatch("run_last", {7'd0, o_run_last},
                                    {7'd0, want.run_last});
                if (o_string_done !== want.string_done)
                    report_mismatch("string_done", {7'd0, o_string_done},
                                    {7'd0, want.string_done});
                if (o_replaced !== want.replaced)
                    report_mismatch("replaced", {7'd0, o_replaced},
                                    {7'd0, want.replaced});
            end
        end
    end

    // Watchdog: a correct run never goes this long without moving a word;
    // the longest legit gap is the receiver hold-off plus a random stall tail.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random pop, or a counted hold-off when one is requested
    // ------------------------------------------------------------------
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                pop = 1'b0;
                hold_left--;
            end else begin
                pop = ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    // Offers one word from a falling edge and returns at the edge that takes it.
    // push stays high on return so back-to-back calls stream a word per cycle unless full.
    task automatic send_unit(input logic [15:0] unit, input logic is_last);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            push = 1'b0;
            @(negedge i_clk);
        end
        push         = 1'b1;
        i_code_unit  = unit;
        i_string_end = is_last;
        do @(posedge i_clk); while (full);
        predict_utf8(unit, is_last);
    endtask

    // drop push, then wait for every predicted byte and a short settle time
    task automatic wait_drained();
        @(negedge i_clk);
        push = 1'b0;
        while (expected_utf8.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic rand_last();
        return $urandom_range(7) == 0;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Range edges of each byte length plus every surrogate case.
    task automatic test_directed();
        send_unit(16'h0000, 1'b0);   // smallest one-byte
        send_unit(16'h007F, 1'b0);   // largest one-byte
        send_unit(16'h0080, 1'b0);   // smallest two-byte
        send_unit(16'h07FF, 1'b0);   // largest two-byte
        send_unit(16'h0800, 1'b0);   // smallest three-byte
        send_unit(16'hD7FF, 1'b0);   // just below surrogates
        send_unit(16'hE000, 1'b0);   // just above surrogates
        send_unit(16'hFFFF, 1'b1);   // largest unit, ends a string
        send_unit(16'hD800, 1'b0);   // high then low, lowest pair -> U+10000
        send_unit(16'hDC00, 1'b0);
        send_unit(16'hDBFF, 1'b0);   // highest pair -> U+10FFFF
        send_unit(16'hDFFF, 1'b0);
        send_unit(16'hDC00, 1'b0);   // reversed order, still a pair
        send_unit(16'hD800, 1'b0);
        send_unit(16'hDFFF, 1'b0);
        send_unit(16'hDBFF, 1'b0);
        send_unit(16'hD800, 1'b0);   // two highs: bad partner
        send_unit(16'hDBFF, 1'b0);
        send_unit(16'hDC00, 1'b0);   // two lows: bad partner
        send_unit(16'hDFFF, 1'b0);
        send_unit(16'hD812, 1'b0);   // high then plain ASCII: bad partner
        send_unit(16'h0041, 1'b0);
        send_unit(16'hDE00, 1'b0);   // low then BMP char closing the string
        send_unit(16'hE000, 1'b1);
        send_unit(16'hD800, 1'b1);   // lone high as last word
        send_unit(16'hDFFF, 1'b1);   // lone low as last word
        send_unit(16'hD83D, 1'b0);   // held high, partner ends the string
        send_unit(16'hDE00, 1'b1);
    endtask

    // Mostly well-formed text with random content, some noise and broken pairs.
    task automatic test_random_text(input int n_units);
        int          sent;
        int          kind;
        logic [15:0] a;
        sent = 0;
        while (sent < n_units) begin
            kind = $urandom_range(9);
            case (kind)
                0, 1: begin
                    send_unit(16'($urandom_range(16'h007F)), rand_last());
                    sent += 1;
                end
                2: begin
                    send_unit(16'($urandom_range(16'h0080, 16'h07FF)), rand_last());
                    sent += 1;
                end
                3, 4: begin
                    if ($urandom_range(1))
                        a = 16'($urandom_range(16'h0800, 16'hD7FF));
                    else
                        a = 16'($urandom_range(16'hE000, 16'hFFFF));
                    send_unit(a, rand_last());
                    sent += 1;
                end
                5, 6: begin
                    send_unit({u16u8_pkg::HIGH_SURR_TAG, 10'($urandom)}, rand_last());
                    send_unit({u16u8_pkg::LOW_SURR_TAG, 10'($urandom)}, rand_last());
                    sent += 2;
                end
                7: begin
                    send_unit({u16u8_pkg::LOW_SURR_TAG, 10'($urandom)}, rand_last());
                    send_unit({u16u8_pkg::HIGH_SURR_TAG, 10'($urandom)}, rand_last());
                    sent += 2;
                end
                8: begin
                    // surrogate then anything: often a bad partner
                    a = $urandom_range(1) ? {u16u8_pkg::HIGH_SURR_TAG, 10'($urandom)}
                                          : {u16u8_pkg::LOW_SURR_TAG, 10'($urandom)};
                    send_unit(a, rand_last());
                    send_unit(16'($urandom), rand_last());
                    sent += 2;
                end
                default: begin
                    send_unit(16'($urandom), rand_last());
                    sent += 1;
                end
            endcase
        end
    endtask

    // Receiver holds off while three- and four-byte text keeps coming:
    // the queue fills and full must stall the sender without losing a word.
    task automatic test_backpressure();
        hold_req = HOLD_CYCLES;
        for (int i = 0; i < 20; i++) begin
            if (i % 4 == 3) begin
                send_unit({u16u8_pkg::HIGH_SURR_TAG, 10'($urandom)}, 1'b0);
                send_unit({u16u8_pkg::LOW_SURR_TAG, 10'($urandom)}, (i == 19));
            end else begin
                send_unit(16'($urandom_range(16'h0800, 16'hD7FF)), 1'b0);
            end
        end
    endtask

    // Sender goes quiet until the block has handed out every byte, then resumes.
    task automatic test_drained_pause();
        test_random_text(8);
        wait_drained();
        test_random_text(8);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // sender idles rarely, receiver often
        tx_idle_pct = 23;
        rx_idle_pct = 64;
        test_directed();
        test_random_text(45);

        // the other way round
        tx_idle_pct = 64;
        rx_idle_pct = 23;
        test_random_text(45);

        // no idling at all
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_backpressure();
        test_drained_pause();
        test_random_text(25);

        wait_drained();
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
